// File: src/bdq_pkg.sv
package bdq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned CmdWidth     = 2;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned OccWidth     = 5;

  typedef enum logic [CmdWidth-1:0] {
    CMD_PUSH_TAIL = 2'd0,
    CMD_POP_HEAD  = 2'd1,
    CMD_POP_TAIL  = 2'd2
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_DONE      = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop_head;
    logic pop_tail;
  } cell_ctl_t;

endpackage

// File: src/bdq_in_if.sv
interface bdq_in_if;
  logic                                       valid;
  logic                                       ready;
  logic        [bdq_pkg::CmdWidth-1:0]        command;
  logic signed [bdq_pkg::ValueWidth-1:0]      push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

// File: src/bdq_out_if.sv
interface bdq_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [bdq_pkg::ValueWidth-1:0]      popped_value;
  logic        [bdq_pkg::StatusWidth-1:0]     status;
  logic        [bdq_pkg::OccWidth-1:0]        occupancy;

  modport source (output valid, output popped_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input occupancy,
                  output ready);
endinterface

// File: src/bdq_cell.sv
// One slot of the deque. Row A keeps entries ordered from the head, row B
// from the tail, so both ends of the queue always sit in the first cell.
module bdq_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bdq_pkg::cell_ctl_t                    ctl_i,
  input  logic signed [bdq_pkg::ValueWidth-1:0] push_value_i,
  input  logic                                  prev_valid_i,
  input  logic signed [bdq_pkg::ValueWidth-1:0] prev_b_i,
  input  logic                                  next_valid_i,
  input  logic signed [bdq_pkg::ValueWidth-1:0] next_a_i,
  input  logic signed [bdq_pkg::ValueWidth-1:0] next_b_i,
  output logic                                  valid_o,
  output logic signed [bdq_pkg::ValueWidth-1:0] a_o,
  output logic signed [bdq_pkg::ValueWidth-1:0] b_o
);

  logic                                  valid_q, valid_d;
  logic signed [bdq_pkg::ValueWidth-1:0] a_q, a_d;
  logic signed [bdq_pkg::ValueWidth-1:0] b_q, b_d;

  always_comb begin
    valid_d = valid_q;
    a_d     = a_q;
    b_d     = b_q;
    if (ctl_i.push) begin
      valid_d = valid_q | prev_valid_i;
      // The first free slot takes the new tail in row A.
      if (!valid_q && prev_valid_i) begin
        a_d = push_value_i;
      end
      b_d = prev_b_i;
    end else if (ctl_i.pop_head) begin
      valid_d = next_valid_i;
      a_d     = next_a_i;
    end else if (ctl_i.pop_tail) begin
      valid_d = next_valid_i;
      b_d     = next_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign b_o     = b_q;

endmodule

// File: src/bounded_deque.sv
// Channel | Dir | Fields                              | Beat
// in_i    | in  | command, push_value                 | one deque operation
// out_o   | out | popped_value, status, occupancy     | one result per operation
//
// Each accepted beat is executed in the cycle it is accepted; its result is
// registered and shows on out_o in the next cycle, so one beat per cycle flows.
// The operation is a single broadcast step of the cell chain, which sets the rate.
// in_i.ready is high whenever the result register is empty or being drained.
// Reset clears the count, every cell's valid bit and the result valid flag.
// A stalled out_o holds its result and backpressures in_i.
module bounded_deque #(
  parameter int unsigned DEPTH = bdq_pkg::DepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_in_if.sink    in_i,
  bdq_out_if.source out_o
);

  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  // The queue is a chain of DEPTH cells. Cell i of row A holds the entry i
  // places behind the head, cell i of row B the entry i places in front of
  // the tail. Valid bits form a thermometer code that matches the count.
  logic                                  cell_valid [DEPTH];
  logic signed [bdq_pkg::ValueWidth-1:0] cell_a     [DEPTH];
  logic signed [bdq_pkg::ValueWidth-1:0] cell_b     [DEPTH];

  logic [CntWidth-1:0] count_q, count_d;
  logic                accept;
  logic                empty, full;
  bdq_pkg::cmd_e       cmd;
  bdq_pkg::cell_ctl_t  ctl;

  logic                                  out_valid_q;
  logic signed [bdq_pkg::ValueWidth-1:0] popped_q, popped_d;
  bdq_pkg::status_e                      status_q, status_d;
  logic [bdq_pkg::OccWidth-1:0]          occ_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign cmd        = bdq_pkg::cmd_e'(in_i.command);
  assign empty      = (count_q == '0);
  assign full       = (count_q == CntWidth'(DEPTH));

  // Decode the beat. An unused command code leaves the queue untouched and
  // reports done with the current occupancy.
  always_comb begin
    ctl      = '0;
    popped_d = '0;
    status_d = bdq_pkg::ST_DONE;
    count_d  = count_q;
    unique case (cmd)
      bdq_pkg::CMD_PUSH_TAIL: begin
        if (full) begin
          status_d = bdq_pkg::ST_OVERFLOW;
        end else begin
          ctl.push = accept;
          count_d  = count_q + CntWidth'(1);
        end
      end
      bdq_pkg::CMD_POP_HEAD: begin
        if (empty) begin
          status_d = bdq_pkg::ST_UNDERFLOW;
        end else begin
          ctl.pop_head = accept;
          popped_d     = cell_a[0];
          count_d      = count_q - CntWidth'(1);
        end
      end
      bdq_pkg::CMD_POP_TAIL: begin
        if (empty) begin
          status_d = bdq_pkg::ST_UNDERFLOW;
        end else begin
          ctl.pop_tail = accept;
          popped_d     = cell_b[0];
          count_d      = count_q - CntWidth'(1);
        end
      end
      default: begin
        status_d = bdq_pkg::ST_DONE;
      end
    endcase
  end

  // The chain itself. The ends see a permanently valid neighbor in front
  // (the incoming value) and an empty one behind.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                                  prev_valid, next_valid;
    logic signed [bdq_pkg::ValueWidth-1:0] prev_b, next_a, next_b;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
      assign prev_b     = in_i.push_value;
    end else begin : g_mid_prev
      assign prev_valid = cell_valid[i-1];
      assign prev_b     = cell_b[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_a     = '0;
      assign next_b     = '0;
    end else begin : g_mid_next
      assign next_valid = cell_valid[i+1];
      assign next_a     = cell_a[i+1];
      assign next_b     = cell_b[i+1];
    end

    bdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .push_value_i (in_i.push_value),
      .prev_valid_i (prev_valid),
      .prev_b_i     (prev_b),
      .next_valid_i (next_valid),
      .next_a_i     (next_a),
      .next_b_i     (next_b),
      .valid_o      (cell_valid[i]),
      .a_o          (cell_a[i]),
      .b_o          (cell_b[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; the occupancy field is the low bits of the new count.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
      occ_q    <= bdq_pkg::OccWidth'(count_d);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = popped_q;
  assign out_o.status       = status_q;
  assign out_o.occupancy    = occ_q;

  // The first cell is occupied exactly when the count is nonzero.
  a_head_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) == cell_valid[0])
    else $error("count and first cell valid disagree");

  // The last cell is occupied exactly when the queue is full.
  a_tail_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntWidth'(DEPTH)) == cell_valid[DEPTH-1])
    else $error("count and last cell valid disagree");

  // With one entry held, both rows hold the same value at the front.
  a_single_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CntWidth'(1)) |-> (cell_a[0] == cell_b[0]))
    else $error("head and tail rows disagree on a single entry");

  // A pop on an empty queue comes back as underflow with the count kept.
  a_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && empty && (cmd == bdq_pkg::CMD_POP_HEAD || cmd == bdq_pkg::CMD_POP_TAIL))
    |=> (out_valid_q && status_q == bdq_pkg::ST_UNDERFLOW && count_q == '0))
    else $error("empty pop not reported as underflow");

endmodule

// File: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QueueDepth = bdq_pkg::DepthDefault;

  // The command field has room for a fourth code that the deque leaves alone.
  localparam logic [bdq_pkg::CmdWidth-1:0] CmdUnused = 2'd3;

  localparam logic [bdq_pkg::ValueWidth-1:0] ValueMax = 32'h7FFF_FFFF;
  localparam logic [bdq_pkg::ValueWidth-1:0] ValueMin = 32'h8000_0000;

  // Number of counted operations in the random part; unused commands do not count.
  localparam int unsigned RandomOps = 1800;

  // The receiver holds off once, for this many cycles, after this many accepted beats.
  localparam int unsigned HoldOffAfter  = 400;
  localparam int unsigned HoldOffCycles = 120;

  // One result beat as the deque reports it.
  typedef struct packed {
    logic signed [bdq_pkg::ValueWidth-1:0] value;
    bdq_pkg::status_e                      status;
    logic [bdq_pkg::OccWidth-1:0]          occ;
  } deque_result_t;

  // One row of the directed plan. A row with reps above one sends that many beats
  // with random values and leaves the expectation to the shadow deque. A row with
  // typed set carries the result that must come back, written out by hand.
  typedef struct packed {
    logic [bdq_pkg::CmdWidth-1:0]   op;
    logic [bdq_pkg::ValueWidth-1:0] value;
    logic [4:0]                     reps;
    logic                           typed;
    logic [bdq_pkg::ValueWidth-1:0] exp_value;
    bdq_pkg::status_e               exp_status;
    logic [bdq_pkg::OccWidth-1:0]   exp_occ;
  } plan_row_t;

  // The directed walk: both pops on an empty deque, the unused command, a tail pop
  // of a single entry, the value extremes, a fill to the brim, a push that is
  // dropped on a full deque, and a head pop that returns the oldest entry.
  localparam plan_row_t DirectedPlan [10] = '{
    '{bdq_pkg::CMD_POP_HEAD,  32'h0,         5'd1,  1'b1, 32'h0,    bdq_pkg::ST_UNDERFLOW, 5'd0},
    '{bdq_pkg::CMD_POP_TAIL,  32'h0,         5'd1,  1'b1, 32'h0,    bdq_pkg::ST_UNDERFLOW, 5'd0},
    '{CmdUnused,              32'h5A5A_A5A5, 5'd1,  1'b1, 32'h0,    bdq_pkg::ST_DONE,      5'd0},
    '{bdq_pkg::CMD_PUSH_TAIL, ValueMax,      5'd1,  1'b1, 32'h0,    bdq_pkg::ST_DONE,      5'd1},
    '{bdq_pkg::CMD_POP_TAIL,  32'h0,         5'd1,  1'b1, ValueMax, bdq_pkg::ST_DONE,      5'd0},
    '{bdq_pkg::CMD_PUSH_TAIL, ValueMin,      5'd1,  1'b1, 32'h0,    bdq_pkg::ST_DONE,      5'd1},
    '{bdq_pkg::CMD_PUSH_TAIL, 32'h0,         5'd15, 1'b0, 32'h0,    bdq_pkg::ST_DONE,      5'd0},
    '{bdq_pkg::CMD_PUSH_TAIL, 32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0,    bdq_pkg::ST_OVERFLOW,  5'd16},
    '{CmdUnused,              32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0,    bdq_pkg::ST_DONE,      5'd16},
    '{bdq_pkg::CMD_POP_HEAD,  32'h0,         5'd1,  1'b1, ValueMin, bdq_pkg::ST_DONE,      5'd15}
  };

  logic clk_i;
  logic rst_ni;

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  bounded_deque #(
    .DEPTH(QueueDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Side band that travels with every input beat: when note_typed is high the
  // expectation for that beat is note_result instead of the shadow deque's answer.
  logic          note_typed;
  deque_result_t note_result;

  // Shadow copy of the deque: a ring of slots with head, tail and fill count.
  logic signed [bdq_pkg::ValueWidth-1:0] shadow_slots [QueueDepth];
  int unsigned                           shadow_head;
  int unsigned                           shadow_tail;
  int unsigned                           shadow_count;

  // Results still owed by the deque, oldest first.
  deque_result_t pending_results [$];

  int unsigned mismatches;
  int unsigned beats_accepted;
  int unsigned results_checked;
  int unsigned burst_left;

  // Tallies for the closing summary, taken from the shadow deque's outcomes.
  int unsigned n_push, n_pop_head, n_pop_tail, n_unused;
  int unsigned n_underflow, n_overflow;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Reset is held at the start of the run and never again.
  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #1_000_000;
    $display("FAIL bounded_deque");
    $finish;
  end

  // Applies one operation to the shadow deque and returns the result it should
  // produce. A pop on an empty deque and a push on a full one leave the state
  // untouched; so does the unused command, which reports the current count.
  function automatic deque_result_t apply_deque_op(logic [bdq_pkg::CmdWidth-1:0] op,
                                                   logic [bdq_pkg::ValueWidth-1:0] value);
    deque_result_t r;
    r.value  = '0;
    r.status = bdq_pkg::ST_DONE;
    if (op == bdq_pkg::CMD_PUSH_TAIL) begin
      n_push += 1;
      if (shadow_count >= QueueDepth) begin
        r.status = bdq_pkg::ST_OVERFLOW;
        n_overflow += 1;
      end else begin
        shadow_slots[shadow_tail] = value;
        shadow_tail  = (shadow_tail + 1) % QueueDepth;
        shadow_count += 1;
      end
    end else if (op == bdq_pkg::CMD_POP_HEAD) begin
      n_pop_head += 1;
      if (shadow_count == 0) begin
        r.status = bdq_pkg::ST_UNDERFLOW;
        n_underflow += 1;
      end else begin
        r.value      = shadow_slots[shadow_head];
        shadow_head  = (shadow_head + 1) % QueueDepth;
        shadow_count -= 1;
      end
    end else if (op == bdq_pkg::CMD_POP_TAIL) begin
      n_pop_tail += 1;
      if (shadow_count == 0) begin
        r.status = bdq_pkg::ST_UNDERFLOW;
        n_underflow += 1;
      end else begin
        // The tail points at the next free slot, so step back first; this also
        // covers the case of a single entry, where head and the new tail meet.
        shadow_tail  = (shadow_tail + QueueDepth - 1) % QueueDepth;
        r.value      = shadow_slots[shadow_tail];
        shadow_count -= 1;
      end
    end else begin
      n_unused += 1;
    end
    r.occ = shadow_count[bdq_pkg::OccWidth-1:0];
    return r;
  endfunction

  // Input acceptance and output checking share one process, so the expectation
  // of a beat is always queued before any result at the same edge is compared.
  always @(posedge clk_i) begin : scoreboard
    deque_result_t model_r;
    deque_result_t exp_r;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        model_r = apply_deque_op(in_ch.command, in_ch.push_value);
        pending_results.push_back(note_typed ? note_result : model_r);
        beats_accepted += 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat arrived with no operation outstanding");
          mismatches += 1;
        end else begin
          exp_r = pending_results.pop_front();
          results_checked += 1;
          if (out_ch.popped_value !== exp_r.value) begin
            $error("popped_value: expected %0d, got %0d", exp_r.value, out_ch.popped_value);
            mismatches += 1;
          end
          if (out_ch.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_ch.status);
            mismatches += 1;
          end
          if (out_ch.occupancy !== exp_r.occ) begin
            $error("occupancy: expected %0d, got %0d", exp_r.occ, out_ch.occupancy);
            mismatches += 1;
          end
        end
      end
    end
  end

  // The receiver switches among a few stall patterns: always ready, a coin toss,
  // ready when the tick count is a multiple of four, and mostly ready. Once, well
  // into the run, it holds off for a long stretch so the result register stays
  // full and the deque has to stall its input while the sender keeps offering beats.
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    bit          held_once;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    held_once = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      tick += 1;
      if (!held_once && beats_accepted >= HoldOffAfter) begin
        held_once = 1'b1;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left -= 1;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 80);
        end
        mode_left -= 1;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= (tick % 4 == 0);
          default: out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Picks a push value: extremes and small numbers often, any pattern otherwise.
  function automatic logic [bdq_pkg::ValueWidth-1:0] draw_value();
    case ($urandom_range(0, 9))
      0: return ValueMax;
      1: return ValueMin;
      2: return '0;
      3: return '1;
      4: return $urandom_range(0, 255);
      5: return -$urandom_range(1, 255);
      default: return $urandom();
    endcase
  endfunction

  // Offers one beat and returns at the edge where it is taken. Valid stays high
  // on return, so a following beat in the same burst goes out back to back.
  task automatic send_op(logic [bdq_pkg::CmdWidth-1:0] op,
                         logic [bdq_pkg::ValueWidth-1:0] value,
                         logic typed, deque_result_t typed_result);
    in_ch.valid      <= 1'b1;
    in_ch.command    <= op;
    in_ch.push_value <= value;
    note_typed       <= typed;
    note_result      <= typed_result;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Ends the current burst when it runs out. Some bursts are followed by no gap
  // at all, which gives long stretches of back-to-back beats.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) burst_left -= 1;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
  endtask

  initial begin : sender
    plan_row_t                    row;
    deque_result_t                row_result;
    int unsigned                  counted;
    int unsigned                  epoch_left;
    int unsigned                  push_pct;
    int unsigned                  roll;
    logic [bdq_pkg::CmdWidth-1:0] op;

    in_ch.valid      = 1'b0;
    in_ch.command    = bdq_pkg::CMD_PUSH_TAIL;
    in_ch.push_value = '0;
    note_typed       = 1'b0;
    note_result      = '0;
    shadow_head      = 0;
    shadow_tail      = 0;
    shadow_count     = 0;
    mismatches       = 0;
    beats_accepted   = 0;
    results_checked  = 0;
    n_push = 0; n_pop_head = 0; n_pop_tail = 0; n_unused = 0;
    n_underflow = 0; n_overflow = 0;
    burst_left = $urandom_range(1, 32);
    counted    = 0;
    epoch_left = 0;
    push_pct   = 50;

    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Directed walk through the plan.
    foreach (DirectedPlan[i]) begin
      row = DirectedPlan[i];
      row_result = '{row.exp_value, row.exp_status, row.exp_occ};
      for (int r = 0; r < row.reps; r++) begin
        send_op(row.op, (row.reps > 1) ? draw_value() : row.value, row.typed, row_result);
        pace();
      end
    end

    // Random operations. The push share changes every epoch so the fill level
    // sweeps the whole range, running into both the empty and the full deque;
    // a small share of unused commands is mixed in as noise.
    while (counted < RandomOps) begin
      if (epoch_left == 0) begin
        case ($urandom_range(0, 4))
          0: push_pct = 15;
          1: push_pct = 35;
          2: push_pct = 50;
          3: push_pct = 65;
          default: push_pct = 85;
        endcase
        epoch_left = 64;
      end
      epoch_left -= 1;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = CmdUnused;
      end else if (roll < 3 + push_pct * 97 / 100) begin
        op = bdq_pkg::CMD_PUSH_TAIL;
      end else begin
        op = $urandom_range(0, 1) ? bdq_pkg::CMD_POP_HEAD : bdq_pkg::CMD_POP_TAIL;
      end
      if (op != CmdUnused) counted += 1;
      send_op(op, draw_value(), 1'b0, '0);
      pace();
    end

    in_ch.valid <= 1'b0;

    // Drain: every owed result must come back, then a few quiet cycles catch
    // any stray beat. The global timer covers a deque that never answers.
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d operations, %0d results checked: %0d pushes, %0d head pops,",
             beats_accepted, results_checked, n_push, n_pop_head);
    $display("  %0d tail pops, %0d unused commands, %0d underflows, %0d overflows.",
             n_pop_tail, n_unused, n_underflow, n_overflow);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS bounded_deque");
    end else begin
      $display("FAIL bounded_deque");
    end
    $finish;
  end

endmodule
